FILE: hdl/text_console_char_writer_macros.svh
// Assertion macros shared by the text console RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// No dependencies; imported by the controller, datapath and top level.
package tcw_pkg;

  // Field widths of the stream beats.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  // Tab stops fall on multiples of four columns.
  localparam int unsigned TAB_BITS = 2;
  localparam logic [2:0]  TAB_STOP = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // capture the input beat
    logic clear_all;    // write one space during the post-reset sweep
    logic tab_load;     // load the glyph count for a put
    logic addr_cur;     // address the cell under the cursor
    logic addr_req;     // address the cell named by the request
    logic glyph_wr;     // store a glyph and advance the cursor
    logic scroll_step;  // clear one cell of the row being recycled
    logic cr_home;      // move the cursor to column zero
    logic cursor_set;   // load the cursor from the request
    logic result_load;  // load the output register
  } tcw_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;     // post-reset sweep is at its final cell
    logic is_put;
    logic is_cr;
    logic is_tab;
    logic is_set;
    logic is_read;
    logic wrap_scroll;    // advancing from the cursor passes the last row
    logic glyph_more;     // more glyphs follow the one being written
    logic glyph_pending;  // glyphs remain after the current scroll
    logic scroll_last;    // row clear is at its final column
    logic out_free;       // output register can take a result
  } tcw_stat_t;

endpackage

FILE: hdl/text_console_char_writer.sv
// Top level of the text console character writer: stream ports, field
// unpacking and packing. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//  Port group  Direction  Payload (tdata, low bit first)
//  in_*        slave      cmd[1:0], char_code[9:2], col[16:10], row[21:17], zero pad
//  out_*       master     read_char[7:0], cursor_col[14:8], cursor_row[19:15],
//                         scrolled[20], zero pad
//
// After reset the grid is swept to spaces one cell per cycle;
// in_tready stays low during the sweep.
// An ordinary character goes decode, write, result; a read goes decode, read, result;
// carriage return, set cursor and the unused command go decode, result.
// A tab writes n spaces (1 to 4), one write state each; each scroll clears
// the recycled row one cell at a time through the single memory write port.
// One item is in work at a time; a finished result waits in the output register
// while the next beat is accepted and worked on.
module text_console_char_writer #(
  parameter int unsigned WIDTH  = 80,
  parameter int unsigned HEIGHT = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd, char_code, col, row, zero pad
  input  logic [tcw_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_char, cursor_col, cursor_row, scrolled, zero pad
  output logic [tcw_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import tcw_pkg::*;

  tcw_ctl_t           ctl;
  tcw_stat_t          st;
  logic [CHAR_W-1:0]  read_char;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic               scrolled;

  // Sequencing.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .ctl      (ctl)
  );

  // Grid, cursor and result register.
  tcw_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .st             (st),
    .in_cmd         (in_tdata[1:0]),
    .in_char_code   (in_tdata[9:2]),
    .in_col         (in_tdata[16:10]),
    .in_row         (in_tdata[21:17]),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_read_char  (read_char),
    .out_cursor_col (cursor_col),
    .out_cursor_row (cursor_row),
    .out_scrolled   (scrolled)
  );

  // Pack the result beat.
  assign out_tdata = {3'b000, scrolled, cursor_row, cursor_col, read_char};

endmodule

FILE: hdl/tcw_ctrl.sv
// Controller state machine for the text console character writer.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::tcw_stat_t st,
  output tcw_pkg::tcw_ctl_t  ctl
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // State register; reset starts the sweep that fills the grid with spaces.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clear_all = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.is_put && st.is_cr) begin
          ctl.cr_home = 1'b1;
          state_nxt   = S_RESULT;
        end else if (st.is_put) begin
          ctl.tab_load = 1'b1;
          ctl.addr_cur = 1'b1;
          state_nxt    = S_WRITE;
        end else if (st.is_set) begin
          ctl.cursor_set = 1'b1;
          state_nxt      = S_RESULT;
        end else if (st.is_read) begin
          ctl.addr_req = 1'b1;
          state_nxt    = S_READ;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_ADDR: begin
        ctl.addr_cur = 1'b1;
        state_nxt    = S_WRITE;
      end
      S_WRITE: begin
        ctl.glyph_wr = 1'b1;
        priority if (st.wrap_scroll) begin
          state_nxt = S_SCROLL;
        end else if (st.glyph_more) begin
          state_nxt = S_ADDR;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SCROLL: begin
        ctl.scroll_step = 1'b1;
        if (st.scroll_last) begin
          state_nxt = st.glyph_pending ? S_ADDR : S_RESULT;
        end
      end
      S_READ: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          ctl.result_load = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/tcw_datapath.sv
// Datapath of the text console: character grid memory, cursor, scroll offset
// and output register. Depends on tcw_pkg and the assertion macro header.
`include "text_console_char_writer_macros.svh"

module tcw_datapath #(
  parameter int unsigned WIDTH  = 80,
  parameter int unsigned HEIGHT = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::tcw_ctl_t             ctl,
  output tcw_pkg::tcw_stat_t            st,
  input  logic [tcw_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]     in_col,
  input  logic [tcw_pkg::ROW_W-1:0]     in_row,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tcw_pkg::CHAR_W-1:0]    out_read_char,
  output logic [tcw_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic                          out_scrolled
);
  import tcw_pkg::*;

  localparam int unsigned CW    = $clog2(WIDTH);
  localparam int unsigned RW    = $clog2(HEIGHT);
  localparam int unsigned RW1   = RW + 1;
  localparam int unsigned DEPTH = WIDTH * HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [CW-1:0]  COL_LAST  = CW'(WIDTH - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(HEIGHT - 1);
  localparam logic [RW:0]    ROW_COUNT = RW1'(HEIGHT);
  localparam logic [AW-1:0]  ROW_PITCH = AW'(WIDTH);
  localparam logic [AW-1:0]  ADDR_LAST = AW'(DEPTH - 1);

  // Request registers.
  logic [CMD_W-1:0]  cmd_r;
  logic [CHAR_W-1:0] char_r;
  logic [CW-1:0]     req_col_r;
  logic [RW-1:0]     req_row_r;

  // Console state.
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     line_r;
  logic [RW-1:0]     top_r;
  logic [AW-1:0]     addr_r;
  logic [CW-1:0]     cnt_r;
  logic [2:0]        tab_r;
  logic              sc_r;

  // Grid memory.
  logic [CHAR_W-1:0] cells [DEPTH];
  logic [CHAR_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [CHAR_W-1:0] mem_wdata;

  // Output register.
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_sc_r;

  logic [CW-1:0]     col_clamped;
  logic [RW-1:0]     row_clamped;
  logic [CW-1:0]     col_sel;
  logic [RW-1:0]     row_sel;
  logic [RW:0]       row_sum;
  logic [RW-1:0]     phys_row;
  logic [AW-1:0]     addr_calc;
  logic [AW-1:0]     scroll_base;

  // Clamp the requested coordinates to the grid.
  always_comb begin
    if (9'(in_col) > 9'(WIDTH - 1)) begin
      col_clamped = COL_LAST;
    end else begin
      col_clamped = CW'(in_col);
    end
    if (7'(in_row) > 7'(HEIGHT - 1)) begin
      row_clamped = ROW_LAST;
    end else begin
      row_clamped = RW'(in_row);
    end
  end

  // Screen row to stored row through the top-row offset, then to a cell address.
  assign col_sel = ctl.addr_req ? req_col_r : col_r;
  assign row_sel = ctl.addr_req ? req_row_r : line_r;
  assign row_sum = {1'b0, top_r} + {1'b0, row_sel};
  assign phys_row = (row_sum >= ROW_COUNT) ? RW'(row_sum - ROW_COUNT) : RW'(row_sum);
  assign addr_calc   = AW'(phys_row) * ROW_PITCH + AW'(col_sel);
  assign scroll_base = AW'(top_r) * ROW_PITCH;

  // Status to the controller.
  always_comb begin
    st               = '0;
    st.clear_last    = (addr_r == ADDR_LAST);
    st.is_put        = (cmd_r == CMD_PUT);
    st.is_set        = (cmd_r == CMD_SET);
    st.is_read       = (cmd_r == CMD_READ);
    st.is_cr         = (char_r == CH_CR);
    st.is_tab        = (char_r == CH_TAB);
    st.wrap_scroll   = (col_r == COL_LAST) && (line_r == ROW_LAST);
    st.glyph_more    = (tab_r > 3'd1);
    st.glyph_pending = (tab_r != 3'd0);
    st.scroll_last   = (cnt_r == COL_LAST);
    st.out_free      = !out_valid_r || out_ready;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r     <= in_cmd;
      char_r    <= in_char_code;
      req_col_r <= col_clamped;
      req_row_r <= row_clamped;
    end
  end

  // Cursor, top-row offset and scroll flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      top_r  <= '0;
      sc_r   <= 1'b0;
    end else begin
      if (ctl.accept) begin
        sc_r <= 1'b0;
      end
      if (ctl.cr_home) begin
        col_r <= '0;
      end
      if (ctl.cursor_set) begin
        col_r  <= req_col_r;
        line_r <= req_row_r;
      end
      if (ctl.glyph_wr) begin
        if (col_r == COL_LAST) begin
          col_r <= '0;
          // On the last row the line stays put and the screen scrolls instead.
          if (line_r != ROW_LAST) begin
            line_r <= line_r + 1'b1;
          end else begin
            sc_r <= 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (ctl.scroll_step && st.scroll_last) begin
        top_r <= (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
      end
    end
  end

  // Cell address: sweep counter after reset, cursor or request address,
  // and a walk over the recycled row during a scroll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      priority if (ctl.clear_all) begin
        addr_r <= addr_r + 1'b1;
      end else if (ctl.addr_cur || ctl.addr_req) begin
        addr_r <= addr_calc;
      end else if (ctl.glyph_wr && st.wrap_scroll) begin
        addr_r <= scroll_base;
      end else if (ctl.scroll_step) begin
        addr_r <= addr_r + 1'b1;
      end else begin
        addr_r <= addr_r;
      end
    end
  end

  // Row-clear column counter and remaining glyph count of a put.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tab_r <= '0;
    end else begin
      if (ctl.glyph_wr && st.wrap_scroll) begin
        cnt_r <= '0;
      end else if (ctl.scroll_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.tab_load) begin
        tab_r <= st.is_tab ? TAB_STOP - 3'(col_r[TAB_BITS-1:0]) : 3'd1;
      end else if (ctl.glyph_wr) begin
        tab_r <= tab_r - 3'd1;
      end
    end
  end

  // Grid memory: one write port and a registered read at the same address.
  assign mem_we    = ctl.clear_all || ctl.scroll_step || ctl.glyph_wr;
  assign mem_wdata = (ctl.glyph_wr && !st.is_tab) ? char_r : CH_SPACE;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[addr_r] <= mem_wdata;
    end
    mem_rd_r <= cells[addr_r];
  end

  // Output register; a loaded result waits here until the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      out_char_r <= st.is_read ? mem_rd_r : '0;
      out_col_r  <= COL_W'(col_r);
      out_row_r  <= ROW_W'(line_r);
      out_sc_r   <= sc_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = out_char_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_sc_r;

  // Checks on the cursor, the memory write sources, the scroll setup and the result slot.
  `TCW_ASSERT_ALWAYS(a_pos_in_grid, clk, rst_n,
    (col_r <= COL_LAST) && (line_r <= ROW_LAST) && (top_r <= ROW_LAST),
    "cursor or top row outside the grid")
  `TCW_ASSERT_ALWAYS(a_one_writer, clk, rst_n,
    $onehot0({ctl.clear_all, ctl.scroll_step, ctl.glyph_wr}),
    "more than one grid write source active")
  `TCW_ASSERT_NEXT(a_scroll_setup, clk, rst_n, ctl.glyph_wr && st.wrap_scroll,
    sc_r && (cnt_r == '0) && (addr_r == scroll_base), "scroll not set up after wrap")
  `TCW_ASSERT_IMPLIES(a_result_slot, clk, rst_n, ctl.result_load, st.out_free,
    "result loaded over a beat not yet taken")

endmodule
